// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Sizes of the ring store, opcode and status codes, sequencer states and the
// result record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Ring store geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ENT_W       = 5;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - DATA_W - ENT_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FWD   = 3'd4,
    OP_READ_BWD   = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ACCESS,
    S_RDATA,
    S_EMIT
  } seq_state_e;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic              last;
    logic [ENT_W-1:0]  entries;
  } res_t;

  // Ring store access request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values in a ring store
//
// Input stream: s_axis_tuser carries the opcode (push front/back, pop
// front/back, read forward/backward), s_axis_tdata the value to push.
// Output stream: one transfer per push or pop, one per stored entry for a
// readout with tlast on the final one; tuser gives status (ok, empty, full).
// An empty pop or readout gives a single empty transfer, a push onto a full
// queue is dropped and flagged full. Opcodes 6 and 7 are consumed silently.
// One item is processed at a time, s_axis_tready is high only when idle.
// A push steps through address calculation, store access and result
// hand-off; a pop or readout entry adds a read-data step after the access,
// and a full or empty case goes from address calculation straight to the
// hand-off. The single port store with registered read and the one shared
// slot adder set these steps.
// Reset clears front pointer and count; store contents need no reset.
// When the receiver stalls, the result waits in the output register and
// the sequencer holds until it can hand over the next one.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic [dq_pkg::OP_W-1:0]        s_axis_tuser,  // [2:0] opcode
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] value_out,
                                                        // [36:32] entries
  output logic [dq_pkg::ST_W-1:0]        m_axis_tuser,  // [1:0] status
  output logic                           m_axis_tlast
);
  import dq_pkg::*;

  logic             in_ready;
  logic             in_xfer;
  logic             out_free;
  logic             res_valid;
  res_t             res;
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] offset;
  logic [IDX_W-1:0] slot;
  ram_req_t         ram_req;
  logic [DATA_W-1:0] rdata;

  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  assign in_xfer       = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Sequencer
  dq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .in_opcode_i (s_axis_tuser),
    .in_value_i  (s_axis_tdata[DATA_W-1:0]),
    .in_ready_o  (in_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .front_o     (front),
    .offset_o    (offset),
    .slot_i      (slot),
    .ram_o       (ram_req),
    .rdata_i     (rdata)
  );

  // Shared slot adder
  dq_slot_adder u_adder (
    .front_i  (front),
    .offset_i (offset),
    .slot_o   (slot)
  );

  // Entry store
  dq_ring_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.entries, out_q.value};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== rtl/dq_slot_adder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_slot_adder: shared ring address unit
// Adds an offset to the front pointer and wraps the sum into the ring.
// ----------------------------------------------------------------------------
module dq_slot_adder (
  input  logic [dq_pkg::IDX_W-1:0] front_i,
  input  logic [dq_pkg::IDX_W-1:0] offset_i,
  output logic [dq_pkg::IDX_W-1:0] slot_o
);
  import dq_pkg::*;

  logic [IDX_W:0] sum;
  logic [IDX_W:0] wrapped;

  // Both operands stay below DEPTH, so one conditional subtract wraps
  always_comb begin
    sum     = {1'b0, front_i} + {1'b0, offset_i};
    wrapped = sum;
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      wrapped = sum - (IDX_W+1)'(DEPTH);
    end
    slot_o = wrapped[IDX_W-1:0];
  end

endmodule

// ===== rtl/dq_ring_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ring_ram: entry store of the ring
// Single port memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module dq_ring_ram (
  input  logic                      clk_i,
  input  dq_pkg::ram_req_t          req_i,
  output logic [dq_pkg::DATA_W-1:0] rdata_o
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_seq: queue sequencer
// Holds front pointer and count, steps each operation through address
// calculation, store access and result hand-off, reusing the slot adder.
// ----------------------------------------------------------------------------
module dq_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input transfer
  input  logic                      in_valid_i,
  input  logic [dq_pkg::OP_W-1:0]   in_opcode_i,
  input  logic [dq_pkg::DATA_W-1:0] in_value_i,
  output logic                      in_ready_o,
  // result hand-off
  input  logic                      out_free_i,
  output logic                      res_valid_o,
  output dq_pkg::res_t              res_o,
  // slot adder
  output logic [dq_pkg::IDX_W-1:0]  front_o,
  output logic [dq_pkg::IDX_W-1:0]  offset_o,
  input  logic [dq_pkg::IDX_W-1:0]  slot_i,
  // ring store
  output dq_pkg::ram_req_t          ram_o,
  input  logic [dq_pkg::DATA_W-1:0] rdata_i
);
  import dq_pkg::*;

  seq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] rval_q, rval_d;
  logic [ST_W-1:0]   rstat_q, rstat_d;
  logic              rlast_q, rlast_d;

  logic              is_push;
  logic              is_pop;
  logic [CNT_W-1:0]  back_off;
  logic [CNT_W-1:0]  rev_off;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    op_q    <= op_d;
    val_q   <= val_d;
    rval_q  <= rval_d;
    rstat_q <= rstat_d;
    rlast_q <= rlast_d;
  end

  assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign is_pop   = (op_q == OP_POP_FRONT)  || (op_q == OP_POP_BACK);
  assign back_off = count_q - CNT_W'(1);
  assign rev_off  = count_q - CNT_W'(1) - CNT_W'(idx_q);

  // Offset into the ring for the shared adder
  always_comb begin
    offset_o = '0;
    if (state_q == S_RDATA) begin
      offset_o = IDX_W'(1);
    end else begin
      unique case (op_q)
        OP_PUSH_FRONT: offset_o = IDX_W'(DEPTH - 1);
        OP_PUSH_BACK:  offset_o = count_q[IDX_W-1:0];
        OP_POP_FRONT:  offset_o = '0;
        OP_POP_BACK:   offset_o = back_off[IDX_W-1:0];
        OP_READ_FWD:   offset_o = idx_q;
        OP_READ_BWD:   offset_o = rev_off[IDX_W-1:0];
        default:       offset_o = '0;
      endcase
    end
  end

  assign front_o = front_q;

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    op_d        = op_q;
    val_d       = val_q;
    rval_d      = rval_q;
    rstat_d     = rstat_q;
    rlast_d     = rlast_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.re    = 1'b0;
    ram_o.addr  = slot_q;
    ram_o.wdata = val_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_opcode_i;
          val_d = in_value_i;
          idx_d = '0;
          // unknown opcodes are dropped without a result
          if (in_opcode_i <= OP_READ_BWD) begin
            state_d = S_CALC;
          end
        end
      end

      S_CALC: begin
        slot_d = slot_i;
        if (is_push && (count_q == CNT_W'(DEPTH))) begin
          rval_d  = '0;
          rstat_d = STAT_FULL;
          rlast_d = 1'b1;
          state_d = S_EMIT;
        end else if (!is_push && (count_q == '0)) begin
          rval_d  = '0;
          rstat_d = STAT_EMPTY;
          rlast_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_ACCESS;
        end
      end

      S_ACCESS: begin
        if (is_push) begin
          ram_o.we = 1'b1;
          if (op_q == OP_PUSH_FRONT) begin
            front_d = slot_q;
          end
          count_d = count_q + CNT_W'(1);
          rval_d  = '0;
          rstat_d = STAT_OK;
          rlast_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          ram_o.re = 1'b1;
          state_d  = S_RDATA;
        end
      end

      S_RDATA: begin
        rval_d  = rdata_i;
        rstat_d = STAT_OK;
        if (is_pop) begin
          rlast_d = 1'b1;
          count_d = count_q - CNT_W'(1);
          if (op_q == OP_POP_FRONT) begin
            front_d = slot_i;
          end
        end else begin
          rlast_d = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          if (rlast_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_CALC;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Result record, count is already updated when it is shown
  always_comb begin
    res_o.value   = rval_q;
    res_o.status  = rstat_q;
    res_o.last    = rlast_q;
    res_o.entries = ENT_W'(count_q);
  end

`ifndef SYNTHESIS
  // Count never passes the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above ring size");

  // Store writes only for a push onto a non-full queue
  a_write_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> (is_push && (count_q < CNT_W'(DEPTH))))
    else $error("store write outside an accepted push");

  // Count moves only from the access or read-data step
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_ACCESS || $past(state_q) == S_RDATA))
    else $error("entry count changed outside an update step");

  // Front pointer moves only on a push front or pop front
  a_front_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_q != $past(front_q)) |->
      ($past(op_q) == OP_PUSH_FRONT || $past(op_q) == OP_POP_FRONT))
    else $error("front pointer moved on wrong operation");
`endif

endmodule
